FILE: rtl/lms_pkg.sv
// lms_pkg: shared types and codes for the led mode scheduler
// mode, command, action and register index codes, plus the structs passed between modules
// no dependencies

package lms_pkg;

  // modes
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_BLINK  = 3'd2;
  localparam logic [2:0] MODE_BREATH = 3'd3;
  localparam logic [2:0] MODE_AUTO   = 3'd4;

  // request kinds
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_TOGGLE  = 2'd2;

  // led drive actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_OFF     = 3'd1;
  localparam logic [2:0] ACT_ON      = 3'd2;
  localparam logic [2:0] ACT_TOGGLE  = 3'd3;
  localparam logic [2:0] ACT_BRIGHT  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_BLINK_INTERVAL = 3'd0;
  localparam logic [2:0] CFG_BREATH_STEP    = 3'd1;
  localparam logic [2:0] CFG_PWM_FLOOR      = 3'd2;
  localparam logic [2:0] CFG_PWM_CEILING    = 3'd3;
  localparam logic [2:0] CFG_WIN_A_START    = 3'd4;
  localparam logic [2:0] CFG_WIN_A_END      = 3'd5;
  localparam logic [2:0] CFG_WIN_B_START    = 3'd6;
  localparam logic [2:0] CFG_WIN_B_END      = 3'd7;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [7:0] HOUR_NONE = 8'hFF;

  typedef struct packed {
    logic [15:0] blink_interval_ms;
    logic [7:0]  breath_step;
    logic [9:0]  pwm_floor;
    logic [9:0]  pwm_ceiling;
    logic [4:0]  window_a_start;
    logic [4:0]  window_a_end;
    logic [4:0]  window_b_start;
    logic [4:0]  window_b_end;
  } lms_cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  new_mode;
    logic [31:0] now_ms;
    logic        time_synced;
    logic [4:0]  hour;
  } lms_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] last_tick;
    logic [9:0]  breath_level;
    logic        breath_rising;
    logic [7:0]  last_auto_hour;
    logic        override_active;
    logic [7:0]  override_hour;
    logic        light_reported_on;
  } lms_state_t;

  typedef struct packed {
    logic [2:0]  led_action;
    logic [9:0]  brightness;
    logic        report_valid;
    logic        report_on;
    logic [2:0]  mode_now;
  } lms_result_t;

endpackage

FILE: rtl/led_mode_scheduler.sv
// led_mode_scheduler: LED mode controller with stream request and result channels
//
// Requests enter on the s_axis group: tuser carries the request kind (tick, set mode,
// manual toggle), tdata the new mode, millisecond count, time-synced flag and hour.
// Every accepted request gives exactly one result on the m_axis group: the LED drive
// action, brightness, light state report and the mode after the request.
// Requests are first captured in an input register; the step logic then updates the
// mode state and loads the output register, which drives m_axis_tvalid_o. One request
// is taken per cycle when the receiver keeps up, since the state loop closes through
// the step logic alone.
// When the receiver stalls, the output register holds its result and the input
// register holds one more request; s_axis_tready drops only while both are full.
// Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i); the user
// must write it only while no request is in flight; the block does not enforce this.
// Reset puts the block into blink mode with the documented register defaults and
// empties both registers.

module led_mode_scheduler #(
  parameter int unsigned BREATH_PERIOD_MS = 20,
  parameter int unsigned PWM_BITS         = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lms_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lms_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // new_mode[2:0], now_ms[34:3], time_synced[35], hour[40:36], zero fill
  input  logic [lms_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // cmd[1:0]
  input  logic [lms_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // led_action[2:0], brightness[12:3], report_valid[13], report_on[14],
  // mode_now[17:15], zero fill
  output logic [lms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  lms_pkg::lms_cfg_t    cfg_q;
  lms_pkg::lms_state_t  state_q, state_d;
  lms_pkg::lms_item_t   item_q;
  lms_pkg::lms_result_t result_d, result_q;
  logic                 in_valid_q, out_valid_q;
  logic                 advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_interval_ms <= 16'd1000;
      cfg_q.breath_step       <= 8'd8;
      cfg_q.pwm_floor         <= 10'd0;
      cfg_q.pwm_ceiling       <= 10'd1023;
      cfg_q.window_a_start    <= 5'd18;
      cfg_q.window_a_end      <= 5'd24;
      cfg_q.window_b_start    <= 5'd0;
      cfg_q.window_b_end      <= 5'd6;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lms_pkg::CFG_BLINK_INTERVAL: cfg_q.blink_interval_ms <= cfg_wdata_i;
        lms_pkg::CFG_BREATH_STEP:    cfg_q.breath_step       <= cfg_wdata_i[7:0];
        lms_pkg::CFG_PWM_FLOOR:      cfg_q.pwm_floor         <= cfg_wdata_i[9:0];
        lms_pkg::CFG_PWM_CEILING:    cfg_q.pwm_ceiling       <= cfg_wdata_i[9:0];
        lms_pkg::CFG_WIN_A_START:    cfg_q.window_a_start    <= cfg_wdata_i[4:0];
        lms_pkg::CFG_WIN_A_END:      cfg_q.window_a_end      <= cfg_wdata_i[4:0];
        lms_pkg::CFG_WIN_B_START:    cfg_q.window_b_start    <= cfg_wdata_i[4:0];
        lms_pkg::CFG_WIN_B_END:      cfg_q.window_b_end      <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q.cmd         <= s_axis_tuser_i[1:0];
      item_q.new_mode    <= s_axis_tdata_i[2:0];
      item_q.now_ms      <= s_axis_tdata_i[34:3];
      item_q.time_synced <= s_axis_tdata_i[35];
      item_q.hour        <= s_axis_tdata_i[40:36];
    end
  end

  lms_core #(
    .BREATH_PERIOD_MS(BREATH_PERIOD_MS),
    .PWM_BITS        (PWM_BITS)
  ) u_core (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode              <= lms_pkg::MODE_BLINK;
      state_q.last_tick         <= '0;
      state_q.breath_level      <= '0;
      state_q.breath_rising     <= 1'b1;
      state_q.last_auto_hour    <= lms_pkg::HOUR_NONE;
      state_q.override_active   <= 1'b0;
      state_q.override_hour     <= lms_pkg::HOUR_NONE;
      state_q.light_reported_on <= 1'b0;
      out_valid_q               <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, result_q.mode_now, result_q.report_on,
                            result_q.report_valid, result_q.brightness, result_q.led_action};

endmodule

FILE: rtl/lms_core.sv
// lms_core: combinational step of the led mode scheduler
// takes the held state, configuration and one request, gives next state and the result
// depends on lms_pkg

module lms_core #(
  parameter int unsigned BREATH_PERIOD_MS = 20,
  parameter int unsigned PWM_BITS         = 10
) (
  input  lms_pkg::lms_cfg_t    cfg_i,
  input  lms_pkg::lms_state_t  state_i,
  input  lms_pkg::lms_item_t   item_i,
  output lms_pkg::lms_state_t  state_o,
  output lms_pkg::lms_result_t result_o
);

  localparam logic [16:0] PwmMax = 17'((32'd1 << PWM_BITS) - 32'd1);

  typedef struct packed {
    logic        hit;
    logic [31:0] last_tick;
    logic [9:0]  level;
    logic        rising;
  } breath_t;

  logic [9:0] top;

  assign top = ({7'd0, cfg_i.pwm_ceiling} > PwmMax) ? PwmMax[9:0] : cfg_i.pwm_ceiling;

  function automatic logic in_window(input logic [4:0] h, input lms_pkg::lms_cfg_t c);
    return (h >= c.window_a_start && h < c.window_a_end) ||
           (h >= c.window_b_start && h < c.window_b_end);
  endfunction

  // one breathing update once the breath period has elapsed, bounces between floor and clamped ceiling
  function automatic breath_t breath_run(input logic [31:0] now,
                                         input lms_pkg::lms_state_t s,
                                         input lms_pkg::lms_cfg_t c,
                                         input logic [9:0] t);
    breath_t r;
    logic [31:0] diff;
    logic signed [11:0] lvl;
    r.hit       = 1'b0;
    r.last_tick = s.last_tick;
    r.level     = s.breath_level;
    r.rising    = s.breath_rising;
    diff        = now - s.last_tick;
    lvl         = '0;
    if (diff >= 32'(BREATH_PERIOD_MS)) begin
      r.hit       = 1'b1;
      r.last_tick = now;
      if (s.breath_rising) begin
        lvl = $signed({2'b00, s.breath_level}) + $signed({4'b0000, c.breath_step});
      end else begin
        lvl = $signed({2'b00, s.breath_level}) - $signed({4'b0000, c.breath_step});
      end
      if (lvl >= $signed({2'b00, t})) begin
        r.level  = t;
        r.rising = 1'b0;
      end else if (lvl <= $signed({2'b00, c.pwm_floor})) begin
        r.level  = c.pwm_floor;
        r.rising = 1'b1;
      end else begin
        r.level = lvl[9:0];
      end
    end
    return r;
  endfunction

  always_comb begin
    lms_pkg::lms_state_t s;
    breath_t b;
    logic [2:0] act;
    logic [9:0] bright;
    logic rep, rep_on, apply, aon, win, breathe, lit;

    s      = state_i;
    b      = '0;
    act    = lms_pkg::ACT_NONE;
    bright = '0;
    rep    = 1'b0;
    rep_on = 1'b0;
    apply  = 1'b0;
    breathe = 1'b0;
    lit    = 1'b0;
    win    = in_window(item_i.hour, cfg_i);
    aon    = item_i.time_synced && win;

    case (item_i.cmd)
      lms_pkg::CMD_TICK: begin
        if (s.mode == lms_pkg::MODE_BLINK && item_i.time_synced) begin
          s.mode            = lms_pkg::MODE_AUTO;
          s.last_auto_hour  = lms_pkg::HOUR_NONE;
          s.override_active = 1'b0;
          s.last_tick       = item_i.now_ms;
        end
        if (s.mode == lms_pkg::MODE_BLINK) begin
          if ((item_i.now_ms - s.last_tick) >= {17'd0, cfg_i.blink_interval_ms[15:1]}) begin
            s.last_tick = item_i.now_ms;
            act         = lms_pkg::ACT_TOGGLE;
          end
        end else if (s.mode == lms_pkg::MODE_BREATH) begin
          breathe = 1'b1;
        end else if (s.mode == lms_pkg::MODE_AUTO) begin
          if (item_i.time_synced && {3'd0, item_i.hour} != s.last_auto_hour) begin
            apply            = 1'b1;
            s.last_auto_hour = {3'd0, item_i.hour};
            if (s.override_active) begin
              if ({3'd0, item_i.hour} != s.override_hour) s.override_active = 1'b0;
              else apply = 1'b0;
            end
            if (apply) begin
              if (win) begin
                s.breath_level  = cfg_i.pwm_floor;
                s.breath_rising = 1'b1;
                s.last_tick     = item_i.now_ms;
              end else begin
                act = lms_pkg::ACT_OFF;
              end
            end
          end
          if (s.override_active) begin
            if (aon) act = lms_pkg::ACT_OFF;
            else breathe = 1'b1;
          end else begin
            breathe = aon;
          end
        end
        if (breathe) begin
          b = breath_run(item_i.now_ms, s, cfg_i, top);
          if (b.hit) begin
            s.last_tick     = b.last_tick;
            s.breath_level  = b.level;
            s.breath_rising = b.rising;
            act             = lms_pkg::ACT_BRIGHT;
            bright          = b.level;
          end
        end
        // light state report for every mode but blink
        if (s.mode != lms_pkg::MODE_BLINK) begin
          if (s.mode == lms_pkg::MODE_ON || s.mode == lms_pkg::MODE_BREATH) lit = 1'b1;
          else if (s.mode == lms_pkg::MODE_AUTO) lit = s.override_active ? !aon : aon;
          if (lit != s.light_reported_on) begin
            s.light_reported_on = lit;
            rep    = 1'b1;
            rep_on = lit;
          end
        end
      end
      lms_pkg::CMD_SET: begin
        if (item_i.new_mode <= lms_pkg::MODE_AUTO) begin
          s.mode = item_i.new_mode;
          case (item_i.new_mode)
            lms_pkg::MODE_OFF:   act = lms_pkg::ACT_OFF;
            lms_pkg::MODE_ON:    act = lms_pkg::ACT_ON;
            lms_pkg::MODE_BLINK: s.last_tick = item_i.now_ms;
            lms_pkg::MODE_BREATH: begin
              s.breath_level  = cfg_i.pwm_floor;
              s.breath_rising = 1'b1;
              s.last_tick     = item_i.now_ms;
            end
            default: begin
              s.last_auto_hour  = lms_pkg::HOUR_NONE;
              s.override_active = 1'b0;
            end
          endcase
        end
      end
      lms_pkg::CMD_TOGGLE: begin
        if (s.mode inside {lms_pkg::MODE_OFF, lms_pkg::MODE_BLINK}) begin
          s.breath_level  = cfg_i.pwm_floor;
          s.breath_rising = 1'b1;
          s.last_tick     = item_i.now_ms;
          s.mode          = lms_pkg::MODE_BREATH;
          rep             = 1'b1;
          rep_on          = 1'b1;
        end else if (s.mode inside {lms_pkg::MODE_ON, lms_pkg::MODE_BREATH}) begin
          s.mode = lms_pkg::MODE_OFF;
          act    = lms_pkg::ACT_OFF;
          rep    = 1'b1;
        end else if (s.mode == lms_pkg::MODE_AUTO && item_i.time_synced) begin
          s.override_hour   = {3'd0, item_i.hour};
          s.override_active = 1'b1;
          rep               = 1'b1;
          if (win) begin
            act = lms_pkg::ACT_OFF;
          end else begin
            s.breath_level  = cfg_i.pwm_floor;
            s.breath_rising = 1'b1;
            s.last_tick     = item_i.now_ms;
            rep_on          = 1'b1;
          end
        end
      end
      default: begin
        // unused request kind: state untouched
      end
    endcase

    state_o               = s;
    result_o.led_action   = act;
    result_o.brightness   = (act == lms_pkg::ACT_BRIGHT) ? bright : 10'd0;
    result_o.report_valid = rep;
    result_o.report_on    = rep && rep_on;
    result_o.mode_now     = s.mode;
  end

endmodule

FILE: rtl/lms_checker.sv
// lms_checker: port-level assertions for the led mode scheduler, with its bind
// watches the result channel only
// depends on lms_pkg and led_mode_scheduler

module lms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [lms_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[17:15] <= lms_pkg::MODE_AUTO)
    else $error("mode out of range");

  // brightness only travels with a set brightness action
  a_bright: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != lms_pkg::ACT_BRIGHT
      |-> m_axis_tdata_o[12:3] == 10'd0)
    else $error("brightness without set brightness action");

  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[14] |-> m_axis_tdata_o[13])
    else $error("report state without report");

  a_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] <= lms_pkg::ACT_BRIGHT && m_axis_tdata_o[23:18] == 6'd0)
    else $error("bad action code or fill bits");

endmodule

bind led_mode_scheduler lms_checker u_lms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
